// ===== rtl/cla_pkg.sv =====
`default_nettype none

package cla_pkg;

  localparam int unsigned CoreCount = 16;
  localparam int unsigned IdxW      = 4;
  localparam int unsigned CntW      = 64;
  localparam int unsigned CoresW    = 5;
  localparam int unsigned WaitW     = 4;

  localparam logic [WaitW-1:0]  SettleTicks = 4'd10;
  localparam logic [CoresW-1:0] MaxCoresRst = 5'd16;

  typedef enum logic {
    CmdSample = 1'b0,
    CmdTick   = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    DecNone = 2'd0,
    DecDown = 2'd1,
    DecUp   = 2'd2
  } decision_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [IdxW-1:0]   core_index;
    logic [CntW-1:0]   busy_count;
    logic [CntW-1:0]   timestamp;
    logic [CoresW-1:0] active_cores;
    logic              cores_ready;
    logic              scale_pending;
  } in_item_t;

  typedef struct packed {
    decision_e         decision;
    logic [CoresW-1:0] target_cores;
    logic              accepted;
    logic [CntW-1:0]   busy_average;
    logic [CntW-1:0]   cycles_average;
  } out_item_t;

  typedef struct packed {
    logic            eval;
    logic [CntW-1:0] avg_busy;
    logic [CntW-1:0] avg_cycles;
  } stats_t;

endpackage

`default_nettype wire

// ===== rtl/cla_stats.sv =====
`default_nettype none

module cla_stats (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  cla_pkg::in_item_t item_i,
  output cla_pkg::stats_t   stats_o
);

  logic [cla_pkg::CntW-1:0] last_busy_q [cla_pkg::CoreCount];
  logic [cla_pkg::CntW-1:0] busy_sum_q, busy_sum_d;
  logic [cla_pkg::CntW-1:0] last_time_q, last_time_d;
  logic [cla_pkg::CntW-1:0] avg_busy_q, avg_busy_d;
  logic [cla_pkg::CntW-1:0] avg_cycles_q, avg_cycles_d;
  logic [cla_pkg::CntW-1:0] sample_delta;
  logic [cla_pkg::CntW-1:0] elapsed;
  logic [cla_pkg::CntW-1:0] wsum_busy;
  logic [cla_pkg::CntW-1:0] wsum_cycles;
  logic                     idx_ok;
  logic                     first_tick;
  logic                     eval;
  logic                     wr_busy;

  always_comb begin
    idx_ok       = ({1'b0, item_i.core_index} < (cla_pkg::IdxW+1)'(cla_pkg::CoreCount));
    sample_delta = item_i.busy_count - last_busy_q[item_i.core_index];
    elapsed      = item_i.timestamp - last_time_q;
    first_tick   = (last_time_q == '0);
    eval         = (item_i.cmd == cla_pkg::CmdTick) && item_i.cores_ready && !first_tick;
    wsum_busy    = (avg_busy_q << 3) - avg_busy_q + busy_sum_q;
    wsum_cycles  = (avg_cycles_q << 3) - avg_cycles_q + elapsed;

    busy_sum_d   = busy_sum_q;
    last_time_d  = last_time_q;
    avg_busy_d   = avg_busy_q;
    avg_cycles_d = avg_cycles_q;
    wr_busy      = 1'b0;

    if (item_i.cmd == cla_pkg::CmdSample) begin
      if (idx_ok) begin
        busy_sum_d = busy_sum_q + sample_delta;
        wr_busy    = 1'b1;
      end
    end else begin
      busy_sum_d = '0;
      if (item_i.cores_ready) begin
        last_time_d = item_i.timestamp;
      end
      if (eval) begin
        avg_busy_d   = wsum_busy >> 3;
        avg_cycles_d = wsum_cycles >> 3;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(cla_pkg::CoreCount); i++) begin
        last_busy_q[i] <= '0;
      end
      busy_sum_q   <= '0;
      last_time_q  <= '0;
      avg_busy_q   <= '0;
      avg_cycles_q <= '0;
    end else if (fire_i) begin
      if (wr_busy) begin
        last_busy_q[item_i.core_index] <= item_i.busy_count;
      end
      busy_sum_q   <= busy_sum_d;
      last_time_q  <= last_time_d;
      avg_busy_q   <= avg_busy_d;
      avg_cycles_q <= avg_cycles_d;
    end
  end

  assign stats_o.eval       = eval;
  assign stats_o.avg_busy   = avg_busy_q;
  assign stats_o.avg_cycles = avg_cycles_q;

endmodule

`default_nettype wire

// ===== rtl/core_load_autoscaler.sv =====
// Channel | Direction | Handshake               | Payload
// in      | input     | in_valid_i/in_stall_o   | in_data_i   (cla_pkg::in_item_t)
// out     | output    | out_valid_o/out_stall_i | out_data_o  (cla_pkg::out_item_t)
// cfg     | input     | cfg_we_i                | cfg_wdata_i (core cap)
//
// One item per cycle unless an output stall holds a tick in the input register.
// Samples retire in the statistics stage and produce no result.
// Stages: input register, statistics update, idle/threshold compute, decision and result.
// Reset clears all statistics and the settle counter; the core cap returns to 16.
// An output stall holds full stages; samples pass ticks held beyond the input register.
`default_nettype none

module core_load_autoscaler (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  cla_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output cla_pkg::out_item_t            out_data_o,
  input  logic                          cfg_we_i,
  input  logic [cla_pkg::CoresW-1:0]    cfg_wdata_i
);

  localparam int unsigned WideW = cla_pkg::CntW + 3;

  logic [cla_pkg::CoresW-1:0] core_cap_q;

  logic                       v0_q;
  cla_pkg::in_item_t          item0_q;
  cla_pkg::stats_t            stats;

  logic                       v1_q;
  logic                       s1_eval_q;
  logic [cla_pkg::CoresW-1:0] s1_cores_q;
  logic                       s1_pend_q;

  logic                       v2_q;
  logic                       s2_eval_q;
  logic [cla_pkg::CoresW-1:0] s2_cores_q;
  logic                       s2_pend_q;
  logic [cla_pkg::CntW-1:0]   s2_idle_q;
  logic [cla_pkg::CntW-1:0]   s2_thr_q;
  logic [cla_pkg::CntW-1:0]   s2_busy_q;
  logic [cla_pkg::CntW-1:0]   s2_cyc_q;

  logic                       out_valid_q;
  cla_pkg::out_item_t         out_q, out_d;
  logic [cla_pkg::WaitW-1:0]  wc_q, wc_d;

  logic fire0, fire1, fire2;
  logic rdy1, rdy2, rdy3;

  logic [cla_pkg::CntW-1:0]   prod;
  logic [cla_pkg::CntW-1:0]   idle;
  logic [cla_pkg::CntW-1:0]   cyc5;
  logic [WideW-1:0]           up_lhs;
  logic [cla_pkg::WaitW-1:0]  wc_inc;
  logic                       settled;
  logic                       do_dn;
  logic                       do_up;

  // handshake chain
  assign rdy3  = !out_valid_q || !out_stall_i;
  assign fire2 = v2_q && rdy3;
  assign rdy2  = !v2_q || rdy3;
  assign fire1 = v1_q && rdy2;
  assign rdy1  = !v1_q || rdy2;
  assign fire0 = v0_q && ((item0_q.cmd == cla_pkg::CmdSample) || rdy1);
  assign in_stall_o = v0_q && !fire0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      core_cap_q <= cla_pkg::MaxCoresRst;
    end else if (cfg_we_i) begin
      core_cap_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      v0_q <= 1'b1;
    end else if (fire0) begin
      v0_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item0_q <= in_data_i;
    end
  end

  cla_stats u_stats (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire0),
    .item_i (item0_q),
    .stats_o(stats)
  );

  // stage 1: ticks only
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (rdy1) begin
      v1_q <= fire0 && (item0_q.cmd == cla_pkg::CmdTick);
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire0 && (item0_q.cmd == cla_pkg::CmdTick)) begin
      s1_eval_q  <= stats.eval;
      s1_cores_q <= item0_q.active_cores;
      s1_pend_q  <= item0_q.scale_pending;
    end
  end

  // stage 2: idle cycles and down threshold from the updated averages
  always_comb begin
    prod = '0;
    for (int i = 0; i < int'(cla_pkg::CoresW); i++) begin
      if (s1_cores_q[i]) begin
        prod = prod + (stats.avg_cycles << i);
      end
    end
    idle = prod - stats.avg_busy;
    cyc5 = stats.avg_cycles + (stats.avg_cycles << 2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (rdy2) begin
      v2_q <= fire1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire1) begin
      s2_eval_q  <= s1_eval_q;
      s2_cores_q <= s1_cores_q;
      s2_pend_q  <= s1_pend_q;
      s2_idle_q  <= idle;
      s2_thr_q   <= cyc5 >> 2;
      s2_busy_q  <= stats.avg_busy;
      s2_cyc_q   <= stats.avg_cycles;
    end
  end

  // stage 3: settle count and decision; idle < cyc/5 iff 5*idle + 5 <= cyc
  always_comb begin
    up_lhs  = ({3'b000, s2_idle_q} << 2) + {3'b000, s2_idle_q} + WideW'(5);
    wc_inc  = (wc_q < cla_pkg::SettleTicks) ? wc_q + 1'b1 : wc_q;
    settled = s2_eval_q && (wc_inc >= cla_pkg::SettleTicks);
    do_dn   = settled && (s2_cores_q > cla_pkg::CoresW'(1)) && (s2_idle_q > s2_thr_q);
    do_up   = settled && !do_dn && (s2_cores_q < core_cap_q)
              && (up_lhs <= {3'b000, s2_cyc_q});

    wc_d = wc_q;
    if (s2_eval_q) begin
      wc_d = (do_dn || do_up) ? '0 : wc_inc;
    end

    out_d.busy_average   = s2_busy_q;
    out_d.cycles_average = s2_cyc_q;
    out_d.accepted       = (do_dn || do_up) && !s2_pend_q;
    priority if (do_dn) begin
      out_d.decision     = cla_pkg::DecDown;
      out_d.target_cores = s2_cores_q - 1'b1;
    end else if (do_up) begin
      out_d.decision     = cla_pkg::DecUp;
      out_d.target_cores = s2_cores_q + 1'b1;
    end else begin
      out_d.decision     = cla_pkg::DecNone;
      out_d.target_cores = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire2) begin
        wc_q <= wc_d;
      end
      if (rdy3) begin
        out_valid_q <= fire2;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire2) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_request_restarts_settle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire2 && (do_dn || do_up)) |=> (wc_q == '0))
    else $error("settle counter not cleared after a request");

  a_no_early_decision : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire2 && (wc_q < cla_pkg::SettleTicks - 1'b1)) |=> (out_q.decision == cla_pkg::DecNone))
    else $error("decision made before settling");

  a_target_matches_decision : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.decision == cla_pkg::DecNone)
                     == (out_data_o.target_cores == '0)))
    else $error("target inconsistent with decision");

  a_accept_needs_request : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.accepted) |-> (out_data_o.decision != cla_pkg::DecNone))
    else $error("accepted without a request");

  a_sample_never_stalls_on_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v0_q && (item0_q.cmd == cla_pkg::CmdSample)) |-> !in_stall_o)
    else $error("sample held behind a pending result");

endmodule

`default_nettype wire

// ===== test/tb_core_load_autoscaler.sv =====
module tb_core_load_autoscaler;
  timeunit 1ns;
  timeprecision 1ps;

  import cla_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int DrainCycles = 8;
  localparam int HoldCycles  = 300;
  localparam int PhaseItems  = 50;

  typedef enum int {
    StallNone,
    StallLight,
    StallHeavy,
    StallToggle
  } stall_mode_e;

  typedef enum int {
    LoadBusy,
    LoadIdle,
    LoadMid
  } load_e;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  in_item_t           in_data_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  out_item_t          out_data_o;
  logic               cfg_we_i    = 1'b0;
  logic [CoresW-1:0]  cfg_wdata_i = '0;

  core_load_autoscaler dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // load monitor state, mirrored from the outside
  logic [CntW-1:0]   busy_base [CoreCount];
  logic [CntW-1:0]   busy_acc   = '0;
  logic [CntW-1:0]   prev_stamp = '0;
  logic [CntW-1:0]   mean_busy  = '0;
  logic [CntW-1:0]   mean_span  = '0;
  logic [WaitW-1:0]  settle_cnt = '0;
  logic [CoresW-1:0] core_cap   = MaxCoresRst;

  out_item_t  expected_results[$];
  in_item_t   pending_items[$];

  logic [CntW-1:0] gen_cnt [CoreCount];
  logic [CntW-1:0] gen_ts = '0;

  int  n_pushed = 0, n_accepted = 0, n_ticks = 0, n_results = 0, n_errors = 0;
  int  n_down = 0, n_up = 0, n_refused = 0, n_cycles = 0;
  bit  hold_req = 1'b0;

  initial begin
    for (int i = 0; i < CoreCount; i++) begin
      busy_base[i] = '0;
      gen_cnt[i]   = '0;
    end
  end

  task automatic track_load(input in_item_t it);
    logic [CntW-1:0] tick_busy, elapsed, idle, ncores;
    out_item_t r;
    if (it.cmd == CmdSample) begin
      busy_acc = busy_acc + (it.busy_count - busy_base[it.core_index]);
      busy_base[it.core_index] = it.busy_count;
    end else begin
      tick_busy = busy_acc;
      busy_acc  = '0;
      r = '0;
      n_ticks++;
      if (it.cores_ready && prev_stamp == '0) begin
        prev_stamp = it.timestamp;
      end else if (it.cores_ready) begin
        elapsed    = it.timestamp - prev_stamp;
        prev_stamp = it.timestamp;
        mean_busy  = (64'd7 * mean_busy + tick_busy) / 64'd8;
        mean_span  = (64'd7 * mean_span + elapsed) / 64'd8;
        if (settle_cnt < SettleTicks) settle_cnt++;
        if (settle_cnt == SettleTicks) begin
          ncores = 64'(it.active_cores);
          idle   = ncores * mean_span - mean_busy;
          if (ncores > 64'd1 && idle > mean_span * 64'd5 / 64'd4) begin
            r.decision     = DecDown;
            r.target_cores = it.active_cores - 5'd1;
            n_down++;
          end else if (it.active_cores < core_cap && idle < mean_span / 64'd5) begin
            r.decision     = DecUp;
            r.target_cores = it.active_cores + 5'd1;
            n_up++;
          end
          if (r.decision != DecNone) begin
            settle_cnt = '0;
            r.accepted = !it.scale_pending;
            if (it.scale_pending) n_refused++;
          end
        end
      end
      r.busy_average   = mean_busy;
      r.cycles_average = mean_span;
      expected_results.push_back(r);
    end
  endtask

  function automatic in_item_t noise_fields();
    in_item_t it;
    it.cmd           = CmdSample;
    it.core_index    = 4'($urandom);
    it.busy_count    = {$urandom, $urandom};
    it.timestamp     = {$urandom, $urandom};
    it.active_cores  = 5'($urandom);
    it.cores_ready   = 1'($urandom);
    it.scale_pending = 1'($urandom);
    return it;
  endfunction

  task automatic push_sample(input logic [IdxW-1:0] idx, input logic [CntW-1:0] cnt);
    in_item_t it;
    it = noise_fields();
    it.cmd        = CmdSample;
    it.core_index = idx;
    it.busy_count = cnt;
    gen_cnt[idx]  = cnt;
    pending_items.push_back(it);
    n_pushed++;
  endtask

  task automatic push_tick(input logic [CntW-1:0] ts, input logic [CoresW-1:0] cores,
                           input bit ready, input bit pend);
    in_item_t it;
    it = noise_fields();
    it.cmd           = CmdTick;
    it.timestamp     = ts;
    it.active_cores  = cores;
    it.cores_ready   = ready;
    it.scale_pending = pend;
    pending_items.push_back(it);
    n_pushed++;
  endtask

  // one tick interval per loop: spread the busy cycles over the active cores (at most 16), then tick
  task automatic run_load(input int n_int, input logic [CoresW-1:0] cores, input load_e kind);
    logic [CntW-1:0] span, busy, share, full, idle_goal, delta;
    int t, i, m, frac;
    m = (cores > 5'd16) ? 16 : int'(cores);
    for (t = 0; t < n_int; t++) begin
      span = 64'($urandom_range(800, 1200));
      case (kind)
        LoadBusy: frac = $urandom_range(0, 150);
        LoadIdle: frac = $urandom_range(1300, 3000);
        default:  frac = $urandom_range(300, 1200);
      endcase
      idle_goal = span * 64'(frac) / 64'd1000;
      full      = 64'(cores) * span;
      busy      = (full > idle_goal) ? full - idle_goal : '0;
      if (m > 0) begin
        share = busy / 64'(m);
        for (i = 0; i < m; i++) begin
          delta = (i == m - 1) ? busy - share * 64'(m - 1) : share;
          push_sample(4'(i), gen_cnt[i] + delta);
        end
      end
      if ($urandom_range(0, 19) == 0) begin
        i = $urandom_range(0, 15);
        push_sample(4'(i), gen_cnt[i]);
      end
      gen_ts = gen_ts + span;
      push_tick(gen_ts, cores, $urandom_range(0, 24) != 0, $urandom_range(0, 3) == 0);
    end
  endtask

  task automatic set_core_cap(input logic [CoresW-1:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    core_cap = v;
  endtask

  task automatic wait_for_results();
    while (pending_items.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // driver: bursts of transfers separated by random gaps
  int burst_left = 0, gap_left = 0;

  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      track_load(in_data_i);
      n_accepted++;
    end
    if (!in_valid_i || !in_stall_o) begin
      if (gap_left > 0 || pending_items.size() == 0 || !rst_ni) begin
        in_valid_i <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        in_valid_i <= 1'b1;
        in_data_i  <= pending_items.pop_front();
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 30);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // receiver: stall pattern in stretches, plus one long hold-off on request
  stall_mode_e stall_mode = StallNone;
  int  stretch_left = 0, hold_left = 0;
  bit  hold_done = 1'b0;

  always @(posedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_left = HoldCycles;
      hold_done = 1'b1;
    end
    if (stretch_left == 0) begin
      stall_mode   = stall_mode_e'($urandom_range(0, 3));
      stretch_left = $urandom_range(5, 60);
    end else begin
      stretch_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      case (stall_mode)
        StallNone:  out_stall_i <= 1'b0;
        StallLight: out_stall_i <= ($urandom_range(0, 3) == 0);
        StallHeavy: out_stall_i <= ($urandom_range(0, 3) != 0);
        default:    out_stall_i <= ~out_stall_i;
      endcase
    end
  end

  // monitor: compare each result transfer with the oldest expectation
  out_item_t want;

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      n_results++;
      if (expected_results.size() == 0) begin
        $error("result transfer with nothing expected");
        n_errors++;
      end else begin
        want = expected_results.pop_front();
        if (out_data_o.decision !== want.decision) begin
          $error("decision: expected %0d, got %0d", want.decision, out_data_o.decision);
          n_errors++;
        end
        if (out_data_o.target_cores !== want.target_cores) begin
          $error("target_cores: expected %0d, got %0d", want.target_cores,
                 out_data_o.target_cores);
          n_errors++;
        end
        if (out_data_o.accepted !== want.accepted) begin
          $error("accepted: expected %0d, got %0d", want.accepted, out_data_o.accepted);
          n_errors++;
        end
        if (out_data_o.busy_average !== want.busy_average) begin
          $error("busy_average: expected %0h, got %0h", want.busy_average,
                 out_data_o.busy_average);
          n_errors++;
        end
        if (out_data_o.cycles_average !== want.cycles_average) begin
          $error("cycles_average: expected %0h, got %0h", want.cycles_average,
                 out_data_o.cycles_average);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CycleLimit) begin
      $display("tb_core_load_autoscaler: done, errors");
      $finish;
    end
  end

  logic [CoresW-1:0] cfg_plan [6] = '{5'd1, 5'd31, 5'd16, 5'd0, 5'd9, 5'd16};

  initial begin
    logic [CoresW-1:0] cores;
    int ph, start, pick, i;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: not ready, zero and all-ones timestamps, wrapping deltas, odd core counts
    push_tick({$urandom, $urandom}, 5'd16, 1'b0, 1'b0);
    push_tick(64'd0, 5'd16, 1'b1, 1'b0);
    push_tick('1, 5'd16, 1'b1, 1'b1);
    push_sample(4'd0, '1);
    push_sample(4'd0, 64'd3);
    push_sample(4'd15, 64'd5);
    push_tick(64'd20, 5'd16, 1'b1, 1'b0);
    push_tick(64'd40, 5'd0, 1'b1, 1'b0);
    push_tick(64'd60, 5'd31, 1'b1, 1'b1);
    push_sample(4'd3, 64'd1000);
    push_tick(64'd70, 5'd1, 1'b0, 1'b0);
    push_tick(64'd80, 5'd1, 1'b1, 1'b0);
    gen_ts = 64'd80;
    wait_for_results();

    for (ph = 0; ph < 6; ph++) begin
      set_core_cap(cfg_plan[ph]);
      if (ph == 0) begin
        for (i = 0; i < CoreCount; i++) push_sample(4'(i), {$urandom, $urandom});
        push_tick(gen_ts, 5'd4, 1'b0, 1'b0);
      end
      if (ph == 2) hold_req = 1'b1;
      start = n_pushed;
      while (n_pushed - start < PhaseItems) begin
        pick = $urandom_range(0, 9);
        if (pick < 6) cores = 5'($urandom_range(1, 4));
        else if (pick < 9) cores = 5'($urandom_range(5, 16));
        else cores = ($urandom_range(0, 1) == 0) ? 5'd0 : 5'($urandom_range(17, 31));
        if ($urandom_range(0, 3) == 0) begin
          push_tick(64'd0, cores, 1'b1, 1'b0);
          gen_ts = {$urandom, $urandom} | 64'd1;
          push_tick(gen_ts, cores, 1'b1, 1'b0);
        end
        run_load($urandom_range(8, 16), cores, load_e'($urandom_range(0, 2)));
      end
      wait_for_results();
    end

    $display("%0d input transfers (%0d ticks), %0d results checked", n_accepted, n_ticks,
             n_results);
    $display("%0d scale-down and %0d scale-up requests, %0d refused as pending", n_down,
             n_up, n_refused);
    if (n_errors == 0) $display("tb_core_load_autoscaler: done, clean");
    else $display("tb_core_load_autoscaler: done, errors");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/cla_pkg.sv
rtl/cla_stats.sv
rtl/core_load_autoscaler.sv
test/tb_core_load_autoscaler.sv
